// ===== rtl/core/hsv2rgb_pkg.sv =====
package hsv2rgb_pkg;

    // Field widths of the words on both channels.
    localparam int HUE_W             = 16;
    localparam int COLOR_BITS        = 8;
    localparam int HUE_FRACTION_BITS = 4;
    localparam int COLOR_MAX         = (1 << COLOR_BITS) - 1;

    // Number of register stages from the input port to the output register.
    localparam int NUM_STAGES = 6;

    // Hue reduction works on whole degrees; the fraction bits ride along.
    localparam int     DEG_W       = HUE_W - HUE_FRACTION_BITS;
    localparam int     DEG_CIRCLE  = 360;
    localparam int     DEG_SECTOR  = 60;
    localparam int     DEG_VAL_W   = 9;
    localparam int     DEG_SHIFT   = DEG_W + DEG_VAL_W;
    localparam longint DEG_RECIP   = ((longint'(1) << DEG_SHIFT) + DEG_CIRCLE - 1) / DEG_CIRCLE;
    localparam int     DEG_RECIP_W = DEG_W + 1;
    localparam int     DEG_PROD_W  = DEG_W + DEG_RECIP_W;
    localparam int     DEG_MOD_W   = 7;

    localparam int FRAC_KEEP_W = HUE_FRACTION_BITS + 1;
    localparam int FRAC_MASK   = (1 << HUE_FRACTION_BITS) - 1;

    // One sector in hue units is 15 << MIX_SHIFT.
    localparam int HUE_SECTOR = DEG_SECTOR << HUE_FRACTION_BITS;
    localparam int T_W        = DEG_MOD_W + HUE_FRACTION_BITS;
    localparam int SEC_W      = 6 + HUE_FRACTION_BITS;
    localparam int MIX_SHIFT  = HUE_FRACTION_BITS + 2;
    localparam int PROD_X_W   = COLOR_BITS + SEC_W + 1;
    localparam int NX_W       = COLOR_BITS + 4;

    // Exact division by 15 through a reciprocal.
    localparam int     DIV15_SHIFT   = COLOR_BITS + 8;
    localparam longint DIV15_RECIP   = ((longint'(1) << DIV15_SHIFT) + 14) / 15;
    localparam int     DIV15_RECIP_W = COLOR_BITS + 5;
    localparam int     DIV15_PROD_W  = NX_W + DIV15_RECIP_W;

    // Chroma product v*s plus half the divisor.
    localparam int CPROD_W     = 2 * COLOR_BITS + 1;
    localparam int CHROMA_HALF = COLOR_MAX / 2;

    typedef enum logic [2:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } sector_t;

    typedef struct packed {
        logic [HUE_W-1:0]      hue;
        logic [COLOR_BITS-1:0] saturation;
        logic [COLOR_BITS-1:0] brightness;
    } hsv_t;

    typedef struct packed {
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [DEG_VAL_W-1:0]   deg;
        logic [FRAC_KEEP_W-1:0] frac;
        logic [COLOR_BITS-1:0]  chroma;
        logic [COLOR_BITS-1:0]  brightness;
    } front_t;

    typedef struct packed {
        logic [DIV15_PROD_W-1:0] x_prod;
        logic [COLOR_BITS-1:0]   chroma;
        logic [COLOR_BITS-1:0]   offset;
        sector_t                 sector;
    } mid_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] valid;
    } pipe_ctrl_t;

endpackage

// ===== rtl/core/hsv2rgb_ctrl.sv =====
module hsv2rgb_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    output hsv2rgb_pkg::pipe_ctrl_t ctrl
);

    logic [hsv2rgb_pkg::NUM_STAGES-1:0] valid_reg;
    logic [hsv2rgb_pkg::NUM_STAGES-1:0] valid_next;
    logic [hsv2rgb_pkg::NUM_STAGES-1:0] adv;

    // A stage may load when it is empty or its contents move on this cycle.
    always_comb begin
        adv[hsv2rgb_pkg::NUM_STAGES-1] = !valid_reg[hsv2rgb_pkg::NUM_STAGES-1] || m_ready;
        for (int k = hsv2rgb_pkg::NUM_STAGES - 2; k >= 0; k--) begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        valid_next[0] = adv[0] ? s_valid : valid_reg[0];
        for (int k = 1; k < hsv2rgb_pkg::NUM_STAGES; k++) begin
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready    = adv[0];
    assign m_valid    = valid_reg[hsv2rgb_pkg::NUM_STAGES-1];
    assign ctrl.load  = adv;
    assign ctrl.valid = valid_reg;

endmodule

// ===== rtl/core/hsv2rgb_front.sv =====
module hsv2rgb_front (
    input  logic                aclk,
    input  logic                load1,
    input  logic                load2,
    input  hsv2rgb_pkg::hsv_t   hsv,
    output hsv2rgb_pkg::front_t front
);

    localparam int B  = hsv2rgb_pkg::COLOR_BITS;
    localparam int F  = hsv2rgb_pkg::HUE_FRACTION_BITS;
    localparam int DW = hsv2rgb_pkg::DEG_W;
    localparam int WW = hsv2rgb_pkg::DEG_W + hsv2rgb_pkg::DEG_VAL_W;

    // Stage 1: reciprocal product for the degree quotient and the chroma product.
    logic [hsv2rgb_pkg::DEG_PROD_W-1:0]  deg_prod_reg;
    logic [DW-1:0]                       hdeg_reg;
    logic [hsv2rgb_pkg::FRAC_KEEP_W-1:0] frac_reg;
    logic [hsv2rgb_pkg::CPROD_W-1:0]     vs_reg;
    logic [B-1:0]                        bright_reg;

    logic [DW-1:0] hdeg_in;

    assign hdeg_in = hsv.hue[hsv2rgb_pkg::HUE_W-1:F];

    always_ff @(posedge aclk) begin
        if (load1) begin
            deg_prod_reg <= hsv2rgb_pkg::DEG_PROD_W'(hdeg_in)
                          * hsv2rgb_pkg::DEG_PROD_W'(hsv2rgb_pkg::DEG_RECIP);
            hdeg_reg     <= hdeg_in;
            frac_reg     <= hsv.hue[F:0];
            vs_reg       <= hsv2rgb_pkg::CPROD_W'(hsv.brightness)
                          * hsv2rgb_pkg::CPROD_W'(hsv.saturation)
                          + hsv2rgb_pkg::CPROD_W'(hsv2rgb_pkg::CHROMA_HALF);
            bright_reg   <= hsv.brightness;
        end
    end

    // Stage 2: degree remainder, and chroma as a divide by 2^B-1 done by folding
    // the high half onto the low half.
    logic [DW-1:0]  quot;
    logic [WW-1:0]  deg_wide;
    logic [B:0]     vs_hi;
    logic [B-1:0]   vs_lo;
    logic [B+1:0]   fold;
    logic [B:0]     chroma_full;
    logic [B-1:0]   chroma;
    hsv2rgb_pkg::front_t front_next;

    always_comb begin
        quot     = DW'(deg_prod_reg >> hsv2rgb_pkg::DEG_SHIFT);
        deg_wide = WW'(hdeg_reg) - WW'(quot) * WW'(hsv2rgb_pkg::DEG_CIRCLE);
        vs_hi    = vs_reg[hsv2rgb_pkg::CPROD_W-1:B];
        vs_lo    = vs_reg[B-1:0];
        fold     = (B+2)'(vs_hi) + (B+2)'(vs_lo);
        if (fold >= (B+2)'(2 * hsv2rgb_pkg::COLOR_MAX)) begin
            chroma_full = vs_hi + (B+1)'(2);
        end else if (fold >= (B+2)'(hsv2rgb_pkg::COLOR_MAX)) begin
            chroma_full = vs_hi + (B+1)'(1);
        end else begin
            chroma_full = vs_hi;
        end
        if (chroma_full > (B+1)'(hsv2rgb_pkg::COLOR_MAX)) begin
            chroma = B'(hsv2rgb_pkg::COLOR_MAX);
        end else begin
            chroma = chroma_full[B-1:0];
        end
        front_next.deg        = deg_wide[hsv2rgb_pkg::DEG_VAL_W-1:0];
        front_next.frac       = frac_reg;
        front_next.chroma     = chroma;
        front_next.brightness = bright_reg;
    end

    always_ff @(posedge aclk) begin
        if (load2) begin
            front <= front_next;
        end
    end

endmodule

// ===== rtl/core/hsv2rgb_shade.sv =====
module hsv2rgb_shade (
    input  logic                aclk,
    input  logic                load3,
    input  logic                load4,
    input  logic                load5,
    input  hsv2rgb_pkg::front_t front,
    output hsv2rgb_pkg::mid_t   mid
);

    localparam int B  = hsv2rgb_pkg::COLOR_BITS;
    localparam int F  = hsv2rgb_pkg::HUE_FRACTION_BITS;
    localparam int VW = hsv2rgb_pkg::DEG_VAL_W;
    localparam int TW = hsv2rgb_pkg::T_W;
    localparam int SW = hsv2rgb_pkg::SEC_W;
    localparam int PW = hsv2rgb_pkg::PROD_X_W;

    // Stage 3: sector, distance from the middle of the sector pair, chroma weight.
    hsv2rgb_pkg::sector_t sector;
    logic [VW-1:0]        deg_base;
    logic [VW-1:0]        deg_off;
    logic [TW-1:0]        t;
    logic [SW-1:0]        d;
    logic [SW-1:0]        w;
    logic [B-1:0]         offset;

    always_comb begin
        if (front.deg >= VW'(5 * hsv2rgb_pkg::DEG_SECTOR)) begin
            sector = hsv2rgb_pkg::SEC_MAGENTA;
        end else if (front.deg >= VW'(4 * hsv2rgb_pkg::DEG_SECTOR)) begin
            sector = hsv2rgb_pkg::SEC_BLUE;
        end else if (front.deg >= VW'(3 * hsv2rgb_pkg::DEG_SECTOR)) begin
            sector = hsv2rgb_pkg::SEC_CYAN;
        end else if (front.deg >= VW'(2 * hsv2rgb_pkg::DEG_SECTOR)) begin
            sector = hsv2rgb_pkg::SEC_GREEN;
        end else if (front.deg >= VW'(hsv2rgb_pkg::DEG_SECTOR)) begin
            sector = hsv2rgb_pkg::SEC_YELLOW;
        end else begin
            sector = hsv2rgb_pkg::SEC_RED;
        end
        case (sector)
            hsv2rgb_pkg::SEC_GREEN, hsv2rgb_pkg::SEC_CYAN: begin
                deg_base = VW'(2 * hsv2rgb_pkg::DEG_SECTOR);
            end
            hsv2rgb_pkg::SEC_BLUE, hsv2rgb_pkg::SEC_MAGENTA: begin
                deg_base = VW'(4 * hsv2rgb_pkg::DEG_SECTOR);
            end
            default: begin
                deg_base = '0;
            end
        endcase
        deg_off = front.deg - deg_base;
        t = (TW'(deg_off[hsv2rgb_pkg::DEG_MOD_W-1:0]) << F)
          | (TW'(front.frac) & TW'(hsv2rgb_pkg::FRAC_MASK));
        if (t >= TW'(hsv2rgb_pkg::HUE_SECTOR)) begin
            d = SW'(t - TW'(hsv2rgb_pkg::HUE_SECTOR));
        end else begin
            d = SW'(TW'(hsv2rgb_pkg::HUE_SECTOR) - t);
        end
        w = SW'(hsv2rgb_pkg::HUE_SECTOR) - d;
        offset = (front.brightness >= front.chroma) ? front.brightness - front.chroma : '0;
    end

    hsv2rgb_pkg::sector_t sector3_reg;
    logic [SW-1:0]        w3_reg;
    logic [B-1:0]         chroma3_reg;
    logic [B-1:0]         offset3_reg;

    always_ff @(posedge aclk) begin
        if (load3) begin
            sector3_reg <= sector;
            w3_reg      <= w;
            chroma3_reg <= front.chroma;
            offset3_reg <= offset;
        end
    end

    // Stage 4: c*w plus half a sector, reduced by the power-of-two part of a sector.
    logic [PW-1:0] prod_x;
    logic [hsv2rgb_pkg::NX_W-1:0] nx;

    assign prod_x = PW'(chroma3_reg) * PW'(w3_reg) + PW'(hsv2rgb_pkg::HUE_SECTOR / 2);
    assign nx     = hsv2rgb_pkg::NX_W'(prod_x >> hsv2rgb_pkg::MIX_SHIFT);

    hsv2rgb_pkg::sector_t         sector4_reg;
    logic [hsv2rgb_pkg::NX_W-1:0] nx4_reg;
    logic [B-1:0]                 chroma4_reg;
    logic [B-1:0]                 offset4_reg;

    always_ff @(posedge aclk) begin
        if (load4) begin
            sector4_reg <= sector3_reg;
            nx4_reg     <= nx;
            chroma4_reg <= chroma3_reg;
            offset4_reg <= offset3_reg;
        end
    end

    // Stage 5: the remaining divide by 15 as a reciprocal product.
    always_ff @(posedge aclk) begin
        if (load5) begin
            mid.x_prod <= hsv2rgb_pkg::DIV15_PROD_W'(nx4_reg)
                        * hsv2rgb_pkg::DIV15_PROD_W'(hsv2rgb_pkg::DIV15_RECIP);
            mid.chroma <= chroma4_reg;
            mid.offset <= offset4_reg;
            mid.sector <= sector4_reg;
        end
    end

endmodule

// ===== rtl/core/hsv2rgb_mix.sv =====
module hsv2rgb_mix (
    input  logic              aclk,
    input  logic              load6,
    input  hsv2rgb_pkg::mid_t mid,
    output hsv2rgb_pkg::rgb_t rgb
);

    localparam int B = hsv2rgb_pkg::COLOR_BITS;

    logic [B:0]   x_full;
    logic [B-1:0] x;
    logic [B-1:0] r1;
    logic [B-1:0] g1;
    logic [B-1:0] b1;
    logic [B:0]   r_sum;
    logic [B:0]   g_sum;
    logic [B:0]   b_sum;
    hsv2rgb_pkg::rgb_t rgb_next;

    always_comb begin
        x_full = mid.x_prod[hsv2rgb_pkg::DIV15_PROD_W-1:hsv2rgb_pkg::DIV15_SHIFT];
        x = (x_full > (B+1)'(hsv2rgb_pkg::COLOR_MAX)) ? B'(hsv2rgb_pkg::COLOR_MAX)
                                                      : x_full[B-1:0];
        case (mid.sector)
            hsv2rgb_pkg::SEC_RED: begin
                r1 = mid.chroma; g1 = x;          b1 = '0;
            end
            hsv2rgb_pkg::SEC_YELLOW: begin
                r1 = x;          g1 = mid.chroma; b1 = '0;
            end
            hsv2rgb_pkg::SEC_GREEN: begin
                r1 = '0;         g1 = mid.chroma; b1 = x;
            end
            hsv2rgb_pkg::SEC_CYAN: begin
                r1 = '0;         g1 = x;          b1 = mid.chroma;
            end
            hsv2rgb_pkg::SEC_BLUE: begin
                r1 = x;          g1 = '0;         b1 = mid.chroma;
            end
            default: begin
                r1 = mid.chroma; g1 = '0;         b1 = x;
            end
        endcase
        r_sum = (B+1)'(r1) + (B+1)'(mid.offset);
        g_sum = (B+1)'(g1) + (B+1)'(mid.offset);
        b_sum = (B+1)'(b1) + (B+1)'(mid.offset);
        rgb_next.red   = r_sum[B] ? B'(hsv2rgb_pkg::COLOR_MAX) : r_sum[B-1:0];
        rgb_next.green = g_sum[B] ? B'(hsv2rgb_pkg::COLOR_MAX) : g_sum[B-1:0];
        rgb_next.blue  = b_sum[B] ? B'(hsv2rgb_pkg::COLOR_MAX) : b_sum[B-1:0];
    end

    always_ff @(posedge aclk) begin
        if (load6) begin
            rgb <= rgb_next;
        end
    end

endmodule

// ===== rtl/core/hsv_to_rgb_converter_top.sv =====
// HSV to RGB converter. Each input word carries hue in sixteenths of a degree
// (reduced modulo a full circle), and saturation and brightness as 8-bit
// fractions where 255 means 1.0; each output word carries 8-bit red, green and
// blue. The block is a six-stage pipeline that takes one word in every clock
// cycle when the output side is not stalled. Each of the multiplications (the
// hue reciprocal and the saturation-brightness product, chroma times the
// sector weight, and the final divide by fifteen) is followed by its own
// register.
// Every stage carries a valid bit and has its own load enable, so a stall on
// the output side only fills empty stages behind it: the block keeps taking
// words until the pipeline is full, and nothing is dropped or repeated.
// The chroma and sector-weight divisions round to nearest with halves rounded
// up, and the block is exact for every input bit pattern.
module hsv_to_rgb_converter_top (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  hsv2rgb_pkg::hsv_t s_hsv,

    output logic              m_valid,
    input  logic              m_ready,
    output hsv2rgb_pkg::rgb_t m_rgb
);

    hsv2rgb_pkg::pipe_ctrl_t ctrl;
    hsv2rgb_pkg::front_t     front;
    hsv2rgb_pkg::mid_t       mid;

    // Valid bits and the ready chain for all six stages.
    hsv2rgb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctrl    (ctrl)
    );

    // Stages 1 and 2: hue reduced to whole degrees plus fraction, and chroma.
    hsv2rgb_front u_front (
        .aclk  (aclk),
        .load1 (ctrl.load[0]),
        .load2 (ctrl.load[1]),
        .hsv   (s_hsv),
        .front (front)
    );

    // Stages 3 to 5: sector, secondary component product and offset.
    hsv2rgb_shade u_shade (
        .aclk  (aclk),
        .load3 (ctrl.load[2]),
        .load4 (ctrl.load[3]),
        .load5 (ctrl.load[4]),
        .front (front),
        .mid   (mid)
    );

    // Stage 6: sector mapping, offset added, clamped into the output register.
    hsv2rgb_mix u_mix (
        .aclk  (aclk),
        .load6 (ctrl.load[5]),
        .mid   (mid),
        .rgb   (m_rgb)
    );

    // An empty first stage must always be able to take a word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !ctrl.valid[0] |-> s_ready)
        else $error("input stalled while the first stage is empty");

    // A word taken in with none leaving adds exactly one to the occupancy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !(m_valid && m_ready))
        |=> $countones(ctrl.valid) == $past($countones(ctrl.valid)) + 1)
        else $error("pipeline occupancy did not grow on an accepted word");

    // A word delivered with none entering removes exactly one from the occupancy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !(s_valid && s_ready))
        |=> $countones(ctrl.valid) + 1 == $past($countones(ctrl.valid)))
        else $error("pipeline occupancy did not drop on a delivered word");

    // Without a delivery, no word may vanish from the pipeline.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_valid && m_ready)
        |=> $countones(ctrl.valid) >= $past($countones(ctrl.valid)))
        else $error("a word was lost inside the pipeline");

endmodule

// ===== test/tb_top.sv =====
module tb_top;

    // Field widths taken from the package.
    localparam int HUE_BITS   = hsv2rgb_pkg::HUE_W;
    localparam int COLOR_W    = hsv2rgb_pkg::COLOR_BITS;

    // Hue steps in one sector and in the whole circle, and the top color code.
    localparam int unsigned SECTOR_STEPS =
        hsv2rgb_pkg::DEG_SECTOR << hsv2rgb_pkg::HUE_FRACTION_BITS;
    localparam int unsigned CIRCLE_STEPS = 6 * SECTOR_STEPS;
    localparam int unsigned COLOR_TOP    = hsv2rgb_pkg::COLOR_MAX;

    // Number of random words after the directed set.
    localparam int RANDOM_WORDS = 650;
    // Length of the long receiver hold-off that backs up the pipeline.
    localparam int HOLD_OFF_CYCLES = 200;
    // Hard cycle limit for the whole run, far above the slowest legal run.
    localparam int CYCLE_LIMIT = 400000;

    // The scoreboard predicts the color for every accepted HSV word and
    // compares each delivered RGB word against the oldest prediction.
    class color_scoreboard;
        hsv2rgb_pkg::rgb_t expected_rgb[$];
        int   mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        function int unsigned clamp_color(int unsigned value);
            return (value > COLOR_TOP) ? COLOR_TOP : value;
        endfunction

        function int unsigned div_round(int unsigned num, int unsigned den);
            return (num + den / 2) / den;
        endfunction

        function hsv2rgb_pkg::rgb_t predict_rgb(hsv2rgb_pkg::hsv_t word);
            int unsigned hue_mod;
            int unsigned sat;
            int unsigned val;
            int unsigned chroma;
            int unsigned in_pair;
            int unsigned mid_dist;
            int unsigned second;
            int unsigned offset;
            int unsigned r1;
            int unsigned g1;
            int unsigned b1;
            hsv2rgb_pkg::sector_t sector;
            hsv2rgb_pkg::rgb_t    color;
            hue_mod  = int'(word.hue) % CIRCLE_STEPS;
            sat      = word.saturation;
            val      = word.brightness;
            chroma   = clamp_color(div_round(val * sat, COLOR_TOP));
            in_pair  = hue_mod % (2 * SECTOR_STEPS);
            mid_dist = (in_pair >= SECTOR_STEPS) ? in_pair - SECTOR_STEPS
                                                 : SECTOR_STEPS - in_pair;
            second   = clamp_color(div_round(chroma * (SECTOR_STEPS - mid_dist),
                                             SECTOR_STEPS));
            offset   = (val >= chroma) ? val - chroma : 0;
            sector   = hsv2rgb_pkg::sector_t'(hue_mod / SECTOR_STEPS);
            case (sector)
                hsv2rgb_pkg::SEC_RED: begin
                    r1 = chroma; g1 = second; b1 = 0;
                end
                hsv2rgb_pkg::SEC_YELLOW: begin
                    r1 = second; g1 = chroma; b1 = 0;
                end
                hsv2rgb_pkg::SEC_GREEN: begin
                    r1 = 0; g1 = chroma; b1 = second;
                end
                hsv2rgb_pkg::SEC_CYAN: begin
                    r1 = 0; g1 = second; b1 = chroma;
                end
                hsv2rgb_pkg::SEC_BLUE: begin
                    r1 = second; g1 = 0; b1 = chroma;
                end
                default: begin
                    r1 = chroma; g1 = 0; b1 = second;
                end
            endcase
            color.red   = COLOR_W'(clamp_color(r1 + offset));
            color.green = COLOR_W'(clamp_color(g1 + offset));
            color.blue  = COLOR_W'(clamp_color(b1 + offset));
            return color;
        endfunction

        function void note_hsv(hsv2rgb_pkg::hsv_t word);
            expected_rgb.push_back(predict_rgb(word));
        endfunction

        function void check_rgb(hsv2rgb_pkg::rgb_t got);
            hsv2rgb_pkg::rgb_t want;
            if (expected_rgb.size() == 0) begin
                $error("unexpected RGB word %h with no prediction pending", got);
                mismatch_count++;
                return;
            end
            want = expected_rgb.pop_front();
            if (got.red !== want.red) begin
                $error("red: expected %0d, got %0d", want.red, got.red);
                mismatch_count++;
            end
            if (got.green !== want.green) begin
                $error("green: expected %0d, got %0d", want.green, got.green);
                mismatch_count++;
            end
            if (got.blue !== want.blue) begin
                $error("blue: expected %0d, got %0d", want.blue, got.blue);
                mismatch_count++;
            end
        endfunction
    endclass

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    hsv2rgb_pkg::hsv_t s_hsv = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    hsv2rgb_pkg::rgb_t m_rgb;

    color_scoreboard color_sb = new();

    // Flags shared by the sender and the receiver. While steady_flow is set,
    // neither side idles. A hold request makes the receiver stall for a long
    // stretch so the pipeline fills and the input side backs up.
    bit steady_flow  = 1'b0;
    bit hold_request = 1'b0;
    int cycle_count  = 0;

    hsv_to_rgb_converter_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_hsv   (s_hsv),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rgb   (m_rgb)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int random_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        if (pick < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one word after an optional idle gap and wait until the block takes
    // it. Valid is only lowered when there is a gap, so back-to-back words keep
    // valid high without a glitch. The prediction is noted at the accepting edge.
    task automatic send_hsv(hsv2rgb_pkg::hsv_t word, int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_hsv   <= word;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        color_sb.note_hsv(word);
    endtask

    task automatic send_directed(logic [HUE_BITS-1:0] hue, logic [COLOR_W-1:0] sat,
                                 logic [COLOR_W-1:0] val);
        hsv2rgb_pkg::hsv_t word;
        word.hue        = hue;
        word.saturation = sat;
        word.brightness = val;
        send_hsv(word, random_gap());
    endtask

    // Random words: most are fully random, some sit next to sector borders, some
    // keep the hue within one circle, and some use the extremes of saturation and brightness.
    function automatic hsv2rgb_pkg::hsv_t random_hsv();
        hsv2rgb_pkg::hsv_t word;
        int   pick;
        pick = $urandom_range(0, 9);
        word.hue        = HUE_BITS'($urandom_range(0, 65535));
        word.saturation = COLOR_W'($urandom_range(0, COLOR_TOP));
        word.brightness = COLOR_W'($urandom_range(0, COLOR_TOP));
        if (pick < 2) begin
            // Near a sector border, possibly beyond the first circle.
            word.hue = HUE_BITS'($urandom_range(0, 11) * SECTOR_STEPS
                                 + $urandom_range(0, 2) - 1 + SECTOR_STEPS);
        end else if (pick == 2) begin
            word.saturation = ($urandom_range(0, 1) != 0) ? COLOR_W'(COLOR_TOP) : '0;
            word.brightness = ($urandom_range(0, 1) != 0) ? COLOR_W'(COLOR_TOP) : '0;
        end else if (pick == 3) begin
            word.hue = HUE_BITS'($urandom_range(0, CIRCLE_STEPS - 1));
        end
        return word;
    endfunction

    // Receiver: checks each accepted RGB word and drives ready with random
    // stalls, the long hold-off on request, and none while steady_flow is set.
    initial begin : receiver
        int  run_left;
        bit  ready_now;
        run_left  = 0;
        ready_now = 1'b1;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                color_sb.check_rgb(m_rgb);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                ready_now    = 1'b0;
                run_left     = HOLD_OFF_CYCLES;
            end else if (run_left > 0) begin
                run_left--;
            end else begin
                ready_now = ($urandom_range(0, 3) != 0);
                run_left  = ready_now ? $urandom_range(0, 20) : random_gap();
            end
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= (steady_flow && run_left <= HOLD_OFF_CYCLES - 1 && ready_now)
                           || steady_flow || ready_now;
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("** hsv_to_rgb_converter_top: FAILED **");
        $finish;
    end

    initial begin : sender
        int idx;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words: every sector with both of its borders, the wrap of
        // the hue circle, hue far beyond one circle, and the extremes of
        // saturation and brightness, including rounding at exactly one half.
        send_directed(16'd0,     8'd255, 8'd255);
        send_directed(16'd480,   8'd255, 8'd255);
        send_directed(16'd959,   8'd255, 8'd255);
        send_directed(16'd960,   8'd255, 8'd255);
        send_directed(16'd1919,  8'd255, 8'd255);
        send_directed(16'd1920,  8'd255, 8'd200);
        send_directed(16'd2879,  8'd200, 8'd255);
        send_directed(16'd2880,  8'd128, 8'd128);
        send_directed(16'd3839,  8'd255, 8'd1);
        send_directed(16'd3840,  8'd1,   8'd255);
        send_directed(16'd4799,  8'd77,  8'd190);
        send_directed(16'd4800,  8'd255, 8'd255);
        send_directed(16'd5759,  8'd255, 8'd255);
        send_directed(16'd5760,  8'd255, 8'd255);
        send_directed(16'd5761,  8'd255, 8'd255);
        send_directed(16'd11520, 8'd100, 8'd150);
        send_directed(16'd65535, 8'd255, 8'd255);
        send_directed(16'd65535, 8'd0,   8'd0);
        send_directed(16'd1234,  8'd0,   8'd255);
        send_directed(16'd4321,  8'd255, 8'd0);
        send_directed(16'd700,   8'd128, 8'd1);
        send_directed(16'd700,   8'd127, 8'd1);
        send_directed(16'd30000, 8'd170, 8'd85);

        // Random words, with a stretch of full throughput on both sides and a
        // long receiver hold-off while the sender keeps offering words.
        for (idx = 0; idx < RANDOM_WORDS; idx++) begin
            if (idx == 100) steady_flow = 1'b1;
            if (idx == 200) steady_flow = 1'b0;
            if (idx == 300) hold_request = 1'b1;
            if ((idx >= 100 && idx < 200) || (idx >= 300 && idx < 340)) begin
                send_hsv(random_hsv(), 0);
            end else begin
                send_hsv(random_hsv(), random_gap());
            end
        end
        s_valid <= 1'b0;

        // Drain: every prediction must be matched, then give the pipeline
        // time to show any stray extra word.
        while (color_sb.expected_rgb.size() != 0) @(posedge aclk);
        repeat (4 * hsv2rgb_pkg::NUM_STAGES) @(posedge aclk);

        if (color_sb.mismatch_count == 0 && color_sb.expected_rgb.size() == 0) begin
            $display("** hsv_to_rgb_converter_top: PASSED **");
        end else begin
            $display("** hsv_to_rgb_converter_top: FAILED **");
        end
        $finish;
    end

endmodule
